// ----- hdl/keypad_scan_pwm_duty_top_assert.svh -----
// assertion macros for the keypad scanner with key-controlled pwm
`ifndef KEYPAD_SCAN_PWM_DUTY_TOP_ASSERT_SVH
`define KEYPAD_SCAN_PWM_DUTY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define KSPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define KSPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KSPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KSPD_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/kspd_pkg.sv -----
`timescale 1ns / 1ps

package kspd_pkg;

  // scanner phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_RELEASE
  } phase_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [1:0] REG_PWM_PERIOD     = 2'd1;
  localparam logic [1:0] REG_DUTY_STEP      = 2'd2;

  // register reset values
  localparam logic [7:0] RST_DEBOUNCE_TICKS = 8'd10;
  localparam logic [7:0] RST_PWM_PERIOD     = 8'd100;
  localparam logic [7:0] RST_DUTY_STEP      = 8'd10;

  // all column lines released
  localparam logic [3:0] COLS_OPEN = 4'hF;

  // digit held after reset
  localparam logic [3:0] RST_DIGIT = 4'd8;

  // last row of the keypad
  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] pwm_period;
    logic [7:0] duty_step;
  } cfg_t;

  // what the scanner reports for one transaction
  typedef struct packed {
    logic [1:0] row;
    logic [3:0] digit;
    logic       event_hit;
  } scan_res_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } dec_t;

  // row rotation 0, 1, 2
  function automatic logic [1:0] next_row(input logic [1:0] r);
    logic [1:0] n;
    n = (r >= LAST_ROW) ? 2'd0 : r + 2'd1;
    return n;
  endfunction

  // single low column on a row to a key digit
  function automatic dec_t decode_key(input logic [1:0] row, input logic [3:0] cols);
    dec_t       d;
    logic [1:0] c;
    logic       one;
    one = 1'b1;
    c   = 2'd0;
    case (cols)
      4'hE:    c = 2'd0;
      4'hD:    c = 2'd1;
      4'hB:    c = 2'd2;
      4'h7:    c = 2'd3;
      default: one = 1'b0;
    endcase
    d.hit   = 1'b0;
    d.digit = 4'd0;
    if (one) begin
      case (row)
        2'd0: begin
          d.hit   = 1'b1;
          d.digit = 4'd1 + {2'b00, c};
        end
        2'd1: begin
          d.hit   = 1'b1;
          d.digit = 4'd5 + {2'b00, c};
        end
        2'd2: begin
          // only the first two columns carry keys on the last row
          if (c == 2'd0) begin
            d.hit   = 1'b1;
            d.digit = 4'd9;
          end else if (c == 2'd1) begin
            d.hit   = 1'b1;
            d.digit = 4'd0;
          end
        end
        default: d.hit = 1'b0;
      endcase
    end
    return d;
  endfunction

endpackage

// ----- hdl/kspd_cfg.sv -----
`timescale 1ns / 1ps

module kspd_cfg import kspd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes, addresses beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
      cfg.pwm_period     <= RST_PWM_PERIOD;
      cfg.duty_step      <= RST_DUTY_STEP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= pwdata[7:0];
        REG_PWM_PERIOD:     cfg.pwm_period     <= pwdata[7:0];
        REG_DUTY_STEP:      cfg.duty_step      <= pwdata[7:0];
        default:            ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE_TICKS: prdata = {24'd0, cfg.debounce_ticks};
      REG_PWM_PERIOD:     prdata = {24'd0, cfg.pwm_period};
      REG_DUTY_STEP:      prdata = {24'd0, cfg.duty_step};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/kspd_scan.sv -----
`timescale 1ns / 1ps

module kspd_scan import kspd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [3:0] col_sense,
  input  logic [7:0] debounce_ticks,
  output scan_res_t  res
);

  phase_t     phase, phase_next;
  logic [1:0] row, row_next;
  logic [7:0] dcount, dcount_next;
  logic [3:0] digit, digit_next;
  logic       cols_open;
  logic       sample_now;
  dec_t       dec;

  assign cols_open  = (col_sense == COLS_OPEN);
  assign sample_now = (dcount <= 8'd1);
  assign dec        = decode_key(row, col_sense);

  // next state
  always_comb begin
    phase_next  = phase;
    row_next    = row;
    dcount_next = dcount;
    digit_next  = digit;
    case (phase)
      PH_DEBOUNCE: begin
        if (!sample_now) begin
          dcount_next = dcount - 8'd1;
        end else begin
          dcount_next = 8'd0;
          if (cols_open) begin
            // press vanished during the wait
            phase_next = PH_IDLE;
            row_next   = next_row(row);
          end else begin
            if (dec.hit) begin
              digit_next = dec.digit;
            end
            phase_next = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (cols_open) begin
          phase_next = PH_IDLE;
          row_next   = next_row(row);
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (cols_open) begin
          row_next = next_row(row);
        end else begin
          // a zero count behaves as one
          dcount_next = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;
          phase_next  = PH_DEBOUNCE;
        end
      end
    endcase
  end

  // outputs for this transaction
  always_comb begin
    res.row       = row;
    res.digit     = digit_next;
    res.event_hit = (phase == PH_DEBOUNCE) && sample_now && !cols_open && dec.hit;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      row    <= 2'd0;
      dcount <= 8'd0;
      digit  <= RST_DIGIT;
    end else if (step) begin
      phase  <= phase_next;
      row    <= row_next;
      dcount <= dcount_next;
      digit  <= digit_next;
    end
  end

endmodule

// ----- hdl/kspd_pwm.sv -----
`timescale 1ns / 1ps

module kspd_pwm import kspd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pwm_advance,
  input  logic [7:0] pwm_period,
  input  logic [7:0] duty_step,
  input  logic [3:0] digit,
  output logic       level
);

  logic [7:0]  count, count_next;
  logic [8:0]  count_inc;
  logic [11:0] thr;

  assign count_inc = {1'b0, count} + 9'd1;

  // counter wraps to zero on reaching the period
  always_comb begin
    count_next = count;
    if (step && pwm_advance) begin
      count_next = (count_inc >= {1'b0, pwm_period}) ? 8'd0 : count_inc[7:0];
    end
  end

  // threshold at full width, compared with the updated count
  assign thr   = {8'd0, digit} * {4'd0, duty_step};
  assign level = ({4'd0, count_next} <= thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 8'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- hdl/keypad_scan_pwm_duty_top.sv -----
`timescale 1ns / 1ps

// Keypad scanner for a 3 x 4 matrix with a key-controlled pwm output. Each
// transaction is one scan tick: the active-low column lines of the row being
// driven plus a pwm advance flag; each gives exactly one result carrying the
// driven row, the pwm level, the held digit and a key event flag. A new
// transaction is taken every clock cycle unless item_stall holds it; the input
// register feeds the state update, which loads the result register. While a
// result waits under stall the input register takes one more transaction and
// then the input stalls until the result is taken. The scanner advances once
// per transaction and the pwm counter once per transaction with the advance
// flag set, so the loop through that state sets the rate. Registers on
// the APB port: 0x0 debounce ticks, 0x4 pwm period, 0x8 duty step per digit;
// write them only while no transaction is in flight.
module keypad_scan_pwm_duty_top import kspd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [3:0]  col_sense,
  input  logic        pwm_advance,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  row_select,
  output logic        pwm_out,
  output logic [3:0]  key_digit,
  output logic        key_event,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "keypad_scan_pwm_duty_top_assert.svh"

  cfg_t       cfg;
  scan_res_t  scan_res;
  logic       s1_valid;
  logic [3:0] s1_cols;
  logic       s1_adv;
  logic       advance;
  logic       step;
  logic       pwm_level;

  // result register frees when empty or taken
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign step       = s1_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_cols <= col_sense;
      s1_adv  <= pwm_advance;
    end
  end

  kspd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kspd_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .col_sense      (s1_cols),
    .debounce_ticks (cfg.debounce_ticks),
    .res            (scan_res)
  );

  kspd_pwm u_pwm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pwm_advance (s1_adv),
    .pwm_period  (cfg.pwm_period),
    .duty_step   (cfg.duty_step),
    .digit       (scan_res.digit),
    .level       (pwm_level)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      row_select <= scan_res.row;
      pwm_out    <= pwm_level;
      key_digit  <= scan_res.digit;
      key_event  <= scan_res.event_hit;
    end
  end

  // checks
  `KSPD_ASSERT_NXT(a_step_gives_result, clk, rst, step, result_valid, "processed transaction lost")
  `KSPD_ASSERT_IMP(a_row_range, clk, rst, result_valid, row_select != 2'd3, "row out of range")
  `KSPD_ASSERT_IMP(a_digit_range, clk, rst, result_valid && key_event, key_digit <= 4'd9, "bad key digit")

endmodule

// ----- dv/tb_keypad_scan_pwm_duty_top.sv -----
`timescale 1ns / 1ps

module tb_keypad_scan_pwm_duty_top;
  import kspd_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  // one expected scan result
  typedef struct packed {
    logic [1:0] row;
    logic       pwm;
    logic [3:0] digit;
    logic       key_hit;
  } scan_tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [3:0]  col_sense = COLS_OPEN;
  logic        pwm_advance = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  row_select;
  logic        pwm_out;
  logic [3:0]  key_digit;
  logic        key_event;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keypad_scan_pwm_duty_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .col_sense    (col_sense),
    .pwm_advance  (pwm_advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_select   (row_select),
    .pwm_out      (pwm_out),
    .key_digit    (key_digit),
    .key_event    (key_event),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // scanner model state and register copies
  logic [1:0] m_row;
  phase_t     m_phase;
  logic [7:0] m_count;
  logic [3:0] m_digit;
  logic [7:0] m_pwm;
  logic [7:0] cfg_debounce;
  logic [7:0] cfg_period;
  logic [7:0] cfg_duty;

  scan_tick_t expected_scans[$];
  logic [3:0] press_cols = COLS_OPEN;
  int         fail_count = 0;
  int         hold_cycles = 0;
  int         stall_left = 0;
  bit         rx_calm = 1'b0;
  int         quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // expected result of one scan tick, advances the model
  task automatic predict_scan_tick(input logic [3:0] cols, input logic adv);
    scan_tick_t  want;
    logic [1:0]  row_now;
    logic        hit;
    logic [8:0]  n;
    int          col;
    int unsigned thr;
    row_now = m_row;
    hit = 1'b0;
    case (m_phase)
      PH_DEBOUNCE: begin
        if (m_count > 8'd1) begin
          m_count = m_count - 8'd1;
        end else begin
          m_count = 8'd0;
          if (cols == COLS_OPEN) begin
            m_phase = PH_IDLE;
            m_row = (m_row >= LAST_ROW) ? 2'd0 : m_row + 2'd1;
          end else begin
            case (cols)
              4'hE: col = 0;
              4'hD: col = 1;
              4'hB: col = 2;
              4'h7: col = 3;
              default: col = -1;
            endcase
            if (col >= 0) begin
              if (m_row == 2'd0) begin
                m_digit = 4'(1 + col);
                hit = 1'b1;
              end else if (m_row == 2'd1) begin
                m_digit = 4'(5 + col);
                hit = 1'b1;
              end else if (col == 0) begin
                m_digit = 4'd9;
                hit = 1'b1;
              end else if (col == 1) begin
                m_digit = 4'd0;
                hit = 1'b1;
              end
            end
            m_phase = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (cols == COLS_OPEN) begin
          m_phase = PH_IDLE;
          m_row = (m_row >= LAST_ROW) ? 2'd0 : m_row + 2'd1;
        end
      end
      default: begin
        m_phase = PH_IDLE;
        if (cols == COLS_OPEN) begin
          m_row = (m_row >= LAST_ROW) ? 2'd0 : m_row + 2'd1;
        end else begin
          m_count = (cfg_debounce == 8'd0) ? 8'd1 : cfg_debounce;
          m_phase = PH_DEBOUNCE;
        end
      end
    endcase
    if (adv) begin
      n = m_pwm + 9'd1;
      if (n >= {1'b0, cfg_period}) n = 9'd0;
      m_pwm = n[7:0];
    end
    // full-width threshold, up to 9 * 255
    thr = m_digit * cfg_duty;
    want.row = row_now;
    want.pwm = (m_pwm <= thr);
    want.digit = m_digit;
    want.key_hit = hit;
    expected_scans.push_back(want);
  endtask

  // offer one transaction and wait for it to be taken
  task automatic send_scan_tick(input logic [3:0] cols, input logic adv);
    @(negedge clk);
    item_valid <= 1'b1;
    col_sense <= cols;
    pwm_advance <= adv;
    do @(posedge clk); while (item_stall);
    predict_scan_tick(cols, adv);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(50, 15);
  endfunction

  // sender pauses until every result is back
  task automatic wait_scans_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write followed by a read-back
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE_TICKS: cfg_debounce = val;
      REG_PWM_PERIOD:     cfg_period = val;
      REG_DUTY_STEP:      cfg_duty = val;
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("register %0d: expected %0d, got %0d", idx, val, prdata[7:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] deb, input logic [7:0] per,
                                input logic [7:0] duty);
    wait_scans_drained();
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_PWM_PERIOD, per);
    write_reg(REG_DUTY_STEP, duty);
  endtask

  // walk to a row, press, hold through debounce, re-sample, release
  task automatic press_key(input logic [1:0] row, input logic [3:0] press,
                           input logic [3:0] resample);
    int settle;
    while (m_row != row || m_phase != PH_IDLE) send_scan_tick(COLS_OPEN, 1'b1);
    send_scan_tick(press, 1'b1);
    settle = (cfg_debounce == 8'd0) ? 1 : cfg_debounce;
    repeat (settle - 1) send_scan_tick(press, 1'b0);
    send_scan_tick(resample, 1'b1);
    if (m_phase == PH_RELEASE) send_scan_tick(COLS_OPEN, 1'b0);
  endtask

  // column pattern that mostly follows a press, hold and release
  task automatic pick_scan_cols(output logic [3:0] cols);
    int r;
    r = $urandom_range(99);
    case (m_phase)
      PH_DEBOUNCE: begin
        if (m_count > 8'd1) begin
          if (r < 80) cols = press_cols;
          else cols = 4'($urandom_range(15));
        end else begin
          if (r < 75) cols = press_cols;
          else if (r < 88) cols = COLS_OPEN;
          else cols = 4'($urandom_range(15));
        end
      end
      PH_RELEASE: begin
        if (r < 55) cols = press_cols;
        else if (r < 90) cols = COLS_OPEN;
        else cols = 4'($urandom_range(15));
      end
      default: begin
        if (r < 45) begin
          cols = COLS_OPEN;
        end else if (r < 85) begin
          press_cols = ~(4'b0001 << $urandom_range(3));
          cols = press_cols;
        end else begin
          press_cols = 4'($urandom_range(15));
          cols = press_cols;
        end
      end
    endcase
  endtask

  task automatic run_random_phase(input int n_items, input bit calm);
    logic [3:0] cols;
    rx_calm = calm;
    repeat (n_items) begin
      pick_scan_cols(cols);
      send_scan_tick(cols, $urandom_range(9) < 7);
      if (!calm) sender_gap(pick_gap());
    end
    rx_calm = 1'b0;
  endtask

  // reset settings, idle rows rotate
  task automatic test_row_rotation();
    send_scan_tick(COLS_OPEN, 1'b1);
    send_scan_tick(COLS_OPEN, 1'b0);
    send_scan_tick(COLS_OPEN, 1'b1);
    send_scan_tick(COLS_OPEN, 1'b1);
  endtask

  task automatic test_key_decode();
    apply_settings(8'd1, 8'd255, 8'd255);
    press_key(2'd0, 4'hE, 4'hE);
    press_key(2'd1, 4'h7, 4'h7);
    press_key(2'd2, 4'hE, 4'hE);
    press_key(2'd2, 4'hD, 4'hD);
  endtask

  // several low columns, or the empty keys of the last row
  task automatic test_unmatched_patterns();
    press_key(2'd2, 4'hB, 4'hB);
    press_key(2'd0, 4'h0, 4'h5);
  endtask

  // press no longer there at the re-sample
  task automatic test_press_gone();
    press_key(2'd1, 4'hD, COLS_OPEN);
  endtask

  task automatic test_tiny_period_zero_debounce();
    apply_settings(8'd0, 8'd0, 8'd0);
    press_key(2'd0, 4'hB, 4'hB);
    send_scan_tick(COLS_OPEN, 1'b1);
    apply_settings(8'd0, 8'd1, 8'd255);
    send_scan_tick(COLS_OPEN, 1'b1);
    send_scan_tick(COLS_OPEN, 1'b1);
  endtask

  task automatic test_random_settings();
    apply_settings(8'd3, 8'd20, 8'd2);
    run_random_phase(95, 1'b0);
    apply_settings(8'd1, 8'd255, 8'd255);
    run_random_phase(110, 1'b0);
    apply_settings(8'd0, 8'd2, 8'd0);
    run_random_phase(80, 1'b1);
    apply_settings(8'd255, 8'd7, 8'd1);
    run_random_phase(90, 1'b0);
    apply_settings(8'd5, 8'd1, 8'd30);
    run_random_phase(90, 1'b0);
    apply_settings(8'd2, 8'd0, 8'd13);
    run_random_phase(90, 1'b0);
    apply_settings(8'($urandom_range(6)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    run_random_phase(100, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure_fill();
    logic [3:0] cols;
    apply_settings(8'd2, 8'd9, 8'd1);
    hold_cycles = 180;
    repeat (40) begin
      pick_scan_cols(cols);
      send_scan_tick(cols, 1'($urandom_range(1)));
    end
    wait_scans_drained();
  endtask

  // receiver stall, random bursts plus requested hold-off
  always @(negedge clk) begin : drive_result_stall
    logic hold;
    int   r;
    hold = 1'b0;
    if (hold_cycles > 0) begin
      hold = 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      hold = 1'b1;
      stall_left--;
    end else if (!rx_calm) begin
      r = $urandom_range(99);
      if (r < 18) begin
        hold = 1'b1;
        stall_left = $urandom_range(2, 0);
      end else if (r < 21) begin
        hold = 1'b1;
        stall_left = $urandom_range(40, 10);
      end
    end
    result_stall <= hold;
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    scan_tick_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_scans.size() == 0) begin
        $error("result with no expectation pending");
        fail_count++;
      end else begin
        want = expected_scans.pop_front();
        if (row_select !== want.row) begin
          $error("row_select: expected %0d, got %0d", want.row, row_select);
          fail_count++;
        end
        if (pwm_out !== want.pwm) begin
          $error("pwm_out: expected %0d, got %0d", want.pwm, pwm_out);
          fail_count++;
        end
        if (key_digit !== want.digit) begin
          $error("key_digit: expected %0d, got %0d", want.digit, key_digit);
          fail_count++;
        end
        if (key_event !== want.key_hit) begin
          $error("key_event: expected %0d, got %0d", want.key_hit, key_event);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    m_row = 2'd0;
    m_phase = PH_IDLE;
    m_count = 8'd0;
    m_digit = RST_DIGIT;
    m_pwm = 8'd0;
    cfg_debounce = RST_DEBOUNCE_TICKS;
    cfg_period = RST_PWM_PERIOD;
    cfg_duty = RST_DUTY_STEP;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_row_rotation();
    test_key_decode();
    test_unmatched_patterns();
    test_press_gone();
    test_tiny_period_zero_debounce();
    test_random_settings();
    test_backpressure_fill();
    wait_scans_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_scans.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- keypad_scan_pwm_duty_top.f -----
+incdir+hdl
hdl/kspd_pkg.sv
hdl/kspd_cfg.sv
hdl/kspd_scan.sv
hdl/kspd_pwm.sv
hdl/keypad_scan_pwm_duty_top.sv
dv/tb_keypad_scan_pwm_duty_top.sv
